@@ rtl/sts_pkg.sv @@
// Package: constants, types and sequencer states of the shortest-counter task scheduler.
`default_nettype none
package sts_pkg;

    localparam int COUNTER_BITS = 16;
    localparam int NUM_TASKS    = 5;
    localparam int LAST_TASK    = 4;
    localparam int ID_W         = $clog2(NUM_TASKS);
    localparam int CNT_W        = COUNTER_BITS + 1;
    localparam int REFILL_W     = 16;
    localparam int REMAIN_W     = 17;
    localparam int RUN_W        = 3;
    localparam int REFILL_KEEP  = (COUNTER_BITS < REFILL_W) ? COUNTER_BITS : REFILL_W;

    typedef logic signed [CNT_W-1:0]    t_cnt;
    typedef logic [ID_W-1:0]            t_id;
    typedef logic [REFILL_W-1:0]        t_refill;
    typedef logic signed [REMAIN_W-1:0] t_remain;
    typedef logic [RUN_W-1:0]           t_run;

    localparam t_id IDLE_TASK  = t_id'(0);
    localparam t_id FIRST_SCAN = t_id'(LAST_TASK);
    localparam t_id LAST_SCAN  = t_id'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC,
        ST_SCAN,
        ST_REFILL,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

@@ rtl/sts_ifs.sv @@
// Interfaces: tick input channel and scheduling result channel.
`default_nettype none
interface sts_in_if;
    logic             valid;
    logic             ready;
    sts_pkg::t_refill refill_task1;
    sts_pkg::t_refill refill_task2;
    sts_pkg::t_refill refill_task3;
    sts_pkg::t_refill refill_task4;

    modport source (output valid, output refill_task1, output refill_task2,
                    output refill_task3, output refill_task4, input ready);
    modport sink   (input valid, input refill_task1, input refill_task2,
                    input refill_task3, input refill_task4, output ready);
endinterface

interface sts_out_if;
    logic             valid;
    logic             ready;
    sts_pkg::t_run    running_task;
    logic             switched;
    logic             refilled;
    sts_pkg::t_remain remaining;

    modport source (output valid, output running_task, output switched,
                    output refilled, output remaining, input ready);
    modport sink   (input valid, input running_task, input switched,
                    input refilled, input remaining, output ready);
endinterface
`default_nettype wire

@@ rtl/shortest_counter_task_scheduler.sv @@
// Top level: shortest-counter task scheduler, one timer tick per input transaction.
// Each tick decrements the running task's slice counter; when it reaches zero or below, a
// single shared compare unit scans tasks 4 down to 1, one counter per cycle, for the smallest
// positive counter (ties go to the higher id). If none qualifies, tasks 1 to 4 are reloaded
// from the tick's refill fields, the idle task's counter is cleared and the scan runs again.
// A tick that keeps the running task goes from the decrement step straight to the done step;
// one that switches tasks first runs the four-step scan through the counter file, and one
// that also reloads runs that scan again after the reload. The result sits in an output
// register, so the next tick may be accepted while it waits to be taken.
`default_nettype none
module shortest_counter_task_scheduler (
    input  wire          i_clk,
    input  wire          i_rst_n,
    sts_in_if.sink       i_in,
    sts_out_if.source    o_out
);

    sts_pkg::t_state  r_state, n_state;
    sts_pkg::t_cnt    r_cnt [sts_pkg::NUM_TASKS];
    sts_pkg::t_cnt    n_cnt [sts_pkg::NUM_TASKS];
    sts_pkg::t_id     r_run, n_run;
    sts_pkg::t_id     r_idx, n_idx;
    sts_pkg::t_id     r_best, n_best;
    sts_pkg::t_cnt    r_best_val, n_best_val;
    logic             r_refilled, n_refilled;
    sts_pkg::t_refill r_refill [sts_pkg::LAST_TASK];

    logic             r_out_valid, n_out_valid;
    sts_pkg::t_run    r_out_task, n_out_task;
    logic             r_out_sw, n_out_sw;
    logic             r_out_rf, n_out_rf;
    sts_pkg::t_remain r_out_rem, n_out_rem;

    sts_pkg::t_id     rd_idx;
    sts_pkg::t_cnt    rd_val;
    sts_pkg::t_cnt    dec_val;
    logic             take;
    logic             in_fire;
    logic             out_free;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready         = (r_state == sts_pkg::ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.running_task = r_out_task;
    assign o_out.switched     = r_out_sw;
    assign o_out.refilled     = r_out_rf;
    assign o_out.remaining    = r_out_rem;

    // single read port into the counter file
    always_comb begin
        unique case (r_state)
            sts_pkg::ST_DEC:  rd_idx = r_run;
            sts_pkg::ST_SCAN: rd_idx = r_idx;
            default:          rd_idx = r_best;
        endcase
    end
    assign rd_val  = r_cnt[rd_idx];
    assign dec_val = rd_val - sts_pkg::t_cnt'(1);
    // shared compare: positive and strictly below the best so far keeps the higher id on ties
    assign take    = (rd_val > 0) && ((r_best == sts_pkg::IDLE_TASK) || (rd_val < r_best_val));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sts_pkg::ST_IDLE;
            r_run       <= sts_pkg::IDLE_TASK;
            r_out_valid <= 1'b0;
            for (int i = 0; i < sts_pkg::NUM_TASKS; i++) begin
                r_cnt[i] <= sts_pkg::t_cnt'(i);
            end
        end else begin
            r_state     <= n_state;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_best     <= n_best;
        r_best_val <= n_best_val;
        r_refilled <= n_refilled;
        r_out_task <= n_out_task;
        r_out_sw   <= n_out_sw;
        r_out_rf   <= n_out_rf;
        r_out_rem  <= n_out_rem;
        if (in_fire) begin
            r_refill[0] <= i_in.refill_task1;
            r_refill[1] <= i_in.refill_task2;
            r_refill[2] <= i_in.refill_task3;
            r_refill[3] <= i_in.refill_task4;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_run       = r_run;
        n_idx       = r_idx;
        n_best      = r_best;
        n_best_val  = r_best_val;
        n_refilled  = r_refilled;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_task  = r_out_task;
        n_out_sw    = r_out_sw;
        n_out_rf    = r_out_rf;
        n_out_rem   = r_out_rem;

        unique case (r_state)
            sts_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_refilled = 1'b0;
                    n_state    = sts_pkg::ST_DEC;
                end
            end
            sts_pkg::ST_DEC: begin
                n_cnt[r_run] = dec_val;
                if (dec_val > 0) begin
                    n_best  = r_run;
                    n_state = sts_pkg::ST_DONE;
                end else begin
                    n_best  = sts_pkg::IDLE_TASK;
                    n_idx   = sts_pkg::FIRST_SCAN;
                    n_state = sts_pkg::ST_SCAN;
                end
            end
            sts_pkg::ST_SCAN: begin
                if (take) begin
                    n_best     = r_idx;
                    n_best_val = rd_val;
                end
                n_idx = r_idx - sts_pkg::t_id'(1);
                if (r_idx == sts_pkg::LAST_SCAN) begin
                    // nothing found after a reload leaves the idle task running
                    if (take || (r_best != sts_pkg::IDLE_TASK) || r_refilled) begin
                        n_state = sts_pkg::ST_DONE;
                    end else begin
                        n_state = sts_pkg::ST_REFILL;
                    end
                end
            end
            sts_pkg::ST_REFILL: begin
                n_cnt[0] = '0;
                for (int i = 1; i <= sts_pkg::LAST_TASK; i++) begin
                    n_cnt[i] = sts_pkg::t_cnt'(r_refill[i-1][sts_pkg::REFILL_KEEP-1:0]);
                end
                n_refilled = 1'b1;
                n_best     = sts_pkg::IDLE_TASK;
                n_idx      = sts_pkg::FIRST_SCAN;
                n_state    = sts_pkg::ST_SCAN;
            end
            sts_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_task  = sts_pkg::t_run'(r_best);
                    n_out_sw    = (r_best != r_run);
                    n_out_rf    = r_refilled;
                    n_out_rem   = sts_pkg::t_remain'(rd_val);
                    n_run       = r_best;
                    n_state     = sts_pkg::ST_IDLE;
                end
            end
            default: n_state = sts_pkg::ST_IDLE;
        endcase
    end

    a_run_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run <= sts_pkg::FIRST_SCAN)
        else $error("running id out of range");

    a_pick_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sts_pkg::ST_DONE) && (r_best != sts_pkg::IDLE_TASK) |-> (rd_val > 0))
        else $error("picked task without a positive counter");

    a_idle_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] >= -1)
        else $error("idle counter below minus one");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sts_pkg::ST_SCAN) |-> (r_idx >= sts_pkg::LAST_SCAN)
                                          && (r_idx <= sts_pkg::FIRST_SCAN))
        else $error("scan index out of range");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == sts_pkg::ST_DEC))
        else $error("accepted tick did not start the decrement step");

endmodule
`default_nettype wire

@@ tb/shortest_counter_task_scheduler_tb.sv @@
// Testbench: shortest-counter task scheduler, ticks predicted and checked per transaction.
`timescale 1ns / 1ps
module shortest_counter_task_scheduler_tb;

    typedef struct {
        sts_pkg::t_run    task_id;
        logic             switched;
        logic             refilled;
        sts_pkg::t_remain remaining;
    } t_sched_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sts_in_if  in_if();
    sts_out_if out_if();

    shortest_counter_task_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // predicted scheduler state
    int slice_cnt [sts_pkg::NUM_TASKS];
    int run_id;

    t_sched_result expected_sched [$];
    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;

    // smallest positive counter among tasks 1..4, ties to the higher id, 0 if none
    function automatic int pick_shortest();
        int best;
        best = 0;
        for (int t = sts_pkg::LAST_TASK; t >= 1; t--) begin
            if (slice_cnt[t] > 0 && (best == 0 || slice_cnt[t] < slice_cnt[best]))
                best = t;
        end
        return best;
    endfunction

    // true when the next tick will reload the counters from its fields
    function automatic bit refill_due();
        if (slice_cnt[run_id] - 1 > 0)
            return 1'b0;
        for (int t = 1; t <= sts_pkg::LAST_TASK; t++) begin
            if (t != run_id && slice_cnt[t] > 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_sched_result advance_scheduler(
        input sts_pkg::t_refill v1, input sts_pkg::t_refill v2,
        input sts_pkg::t_refill v3, input sts_pkg::t_refill v4);
        t_sched_result res;
        int            prev;
        int            nxt;
        logic [63:0]   keep_mask;
        keep_mask    = (64'd1 << sts_pkg::REFILL_KEEP) - 64'd1;
        prev         = run_id;
        res.refilled = 1'b0;
        slice_cnt[run_id] -= 1;
        if (slice_cnt[run_id] <= 0) begin
            nxt = pick_shortest();
            if (nxt == 0) begin
                slice_cnt[0] = 0;
                slice_cnt[1] = int'(64'(v1) & keep_mask);
                slice_cnt[2] = int'(64'(v2) & keep_mask);
                slice_cnt[3] = int'(64'(v3) & keep_mask);
                slice_cnt[4] = int'(64'(v4) & keep_mask);
                res.refilled = 1'b1;
                nxt          = pick_shortest();
            end
            run_id = nxt;
        end
        res.task_id   = sts_pkg::t_run'(run_id);
        res.switched  = (run_id != prev);
        res.remaining = sts_pkg::t_remain'(slice_cnt[run_id]);
        return res;
    endfunction

    // one tick transaction; called right after a rising edge
    task automatic send_tick(input sts_pkg::t_refill v1, input sts_pkg::t_refill v2,
                             input sts_pkg::t_refill v3, input sts_pkg::t_refill v4);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.refill_task1 <= v1;
        in_if.refill_task2 <= v2;
        in_if.refill_task3 <= v3;
        in_if.refill_task4 <= v4;
        do
            @(posedge i_clk);
        while (!in_if.ready);
        expected_sched.push_back(advance_scheduler(v1, v2, v3, v4));
    endtask

    // run ticks with junk refill fields until all tasks are spent, then reload with these
    task automatic run_to_refill(input sts_pkg::t_refill v1, input sts_pkg::t_refill v2,
                                 input sts_pkg::t_refill v3, input sts_pkg::t_refill v4);
        while (!refill_due())
            send_tick(sts_pkg::t_refill'($urandom), sts_pkg::t_refill'($urandom),
                      sts_pkg::t_refill'($urandom), sts_pkg::t_refill'($urandom));
        send_tick(v1, v2, v3, v4);
    endtask

    task automatic wait_all_results();
        in_if.valid <= 1'b0;
        while (expected_sched.size() != 0)
            @(posedge i_clk);
    endtask

    // mostly short slices so that switches and reloads come often
    function automatic sts_pkg::t_refill pick_refill_value();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return sts_pkg::t_refill'(0);
        else if (r < 80)
            return sts_pkg::t_refill'($urandom_range(6, 1));
        else if (r < 99)
            return sts_pkg::t_refill'($urandom_range(40, 1));
        return sts_pkg::t_refill'($urandom_range(150, 60));
    endfunction

    // from reset tasks 1..4 run out in turn; the first reload is all zero, so idle runs
    task automatic test_startup_zero_refill();
        run_to_refill(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // idle drops to -1 on its own tick; equal counters go to the higher id
    task automatic test_idle_exhausted_tie();
        run_to_refill(16'd1, 16'd2, 16'd2, 16'd1);
    endtask

    task automatic test_partial_zero_refill();
        run_to_refill(16'd0, 16'd0, 16'd1, 16'd0);
        run_to_refill(16'd1, 16'd1, 16'd1, 16'd1);
    endtask

    task automatic test_random_ticks(input int n_ticks);
        for (int i = 0; i < n_ticks; i++) begin
            if (refill_due())
                send_tick(pick_refill_value(), pick_refill_value(),
                          pick_refill_value(), pick_refill_value());
            else
                send_tick(sts_pkg::t_refill'($urandom), sts_pkg::t_refill'($urandom),
                          sts_pkg::t_refill'($urandom), sts_pkg::t_refill'($urandom));
        end
    endtask

    // kept for last: large slices would hold one task for the rest of the run
    task automatic test_extreme_refill();
        run_to_refill(16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFE);
        for (int i = 0; i < 4; i++)
            send_tick(sts_pkg::t_refill'($urandom), sts_pkg::t_refill'($urandom),
                      sts_pkg::t_refill'($urandom), sts_pkg::t_refill'($urandom));
    endtask

    always @(posedge i_clk) begin
        t_sched_result exp_r;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_sched.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: task %0d sw %0b rf %0b rem %0d",
                             out_if.running_task, out_if.switched, out_if.refilled,
                             out_if.remaining);
            end else begin
                exp_r = expected_sched.pop_front();
                if (out_if.running_task !== exp_r.task_id || out_if.switched !== exp_r.switched
                    || out_if.refilled !== exp_r.refilled
                    || out_if.remaining !== exp_r.remaining) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected task %0d sw %0b rf %0b rem %0d",
                                 exp_r.task_id, exp_r.switched, exp_r.refilled,
                                 exp_r.remaining);
                        $display("          got      task %0d sw %0b rf %0b rem %0d",
                                 out_if.running_task, out_if.switched, out_if.refilled,
                                 out_if.remaining);
                    end
                end
            end
        end
        if (!i_rst_n)
            out_if.ready <= 1'b0;
        else
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        for (int t = 0; t < sts_pkg::NUM_TASKS; t++)
            slice_cnt[t] = t;
        run_id             = 0;
        mismatches         = 0;
        send_idle_pct      = 0;
        recv_idle_pct      = 0;
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.refill_task1 <= '0;
        in_if.refill_task2 <= '0;
        in_if.refill_task3 <= '0;
        in_if.refill_task4 <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_startup_zero_refill();
        test_idle_exhausted_tie();
        test_partial_zero_refill();
        wait_all_results();

        send_idle_pct = 25;
        recv_idle_pct = 72;
        test_random_ticks(450);
        wait_all_results();

        send_idle_pct = 72;
        recv_idle_pct = 25;
        test_random_ticks(450);
        wait_all_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_ticks(450);
        wait_all_results();

        test_extreme_refill();
        wait_all_results();
        repeat (20) @(posedge i_clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
